/* hw/rtl/dsf_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// dsf_pkg
// Shared constants for the damped spring force pipeline: default coordinate
// width, configuration port widths, register indexes and reset values.
// ============================================================================
package dsf_pkg;

    // Default coordinate width (signed Q16.16 at 32 bits)
    localparam int DSF_COORD_WIDTH = 32;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    // Register field widths
    localparam int REST_WIDTH = 31;
    localparam int GAIN_WIDTH = 24;
    localparam int DZ_WIDTH   = 16;

    // Gains are Q8.16
    localparam int GAIN_FRAC = 16;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REST_LENGTH  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPRING_GAIN  = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DAMPING_GAIN = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADZONE     = 8'd3;

    // Reset values
    localparam logic [REST_WIDTH-1:0] RST_REST_LENGTH  = 31'd0;
    localparam logic [GAIN_WIDTH-1:0] RST_SPRING_GAIN  = 24'd65536;
    localparam logic [GAIN_WIDTH-1:0] RST_DAMPING_GAIN = 24'd0;
    localparam logic [DZ_WIDTH-1:0]   RST_DEADZONE     = 16'd655;

endpackage

/* hw/rtl/damped_spring_force.sv */
`timescale 1ns / 1ps
// ============================================================================
// damped_spring_force
// Damped 2D Hooke spring in signed fixed point. Length by a digit-serial
// square root pipeline, direction by two restoring divide pipelines, then
// deadzone, spring/damping gains and output saturation.
// ============================================================================
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+----------------------------------
//  command   | i_start / o_busy            | i_first_pos_*, i_second_pos_*,
//            |                             | i_first_vel_*, i_second_vel_*
//  result    | o_valid (one-cycle strobe)  | o_first_force_*, o_second_force_*
//  config    | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One spring per cycle; o_busy stays low. The square root pipeline has one
// stage per root bit and the divide pipelines one stage per quotient bit.
// Reset (synchronous, active low) clears the stage valid bits and loads the
// register defaults. The receiver cannot stall, so the pipeline never holds.
// Config writes are always taken (o_cfg_ready high); unknown indexes are dropped.
//
module damped_spring_force
    import dsf_pkg::*;
#(
    parameter int COORD_WIDTH = DSF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_first_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_vel_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_vel_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_vel_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_vel_y,

    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_first_force_x,
    output logic signed [COORD_WIDTH-1:0] o_first_force_y,
    output logic signed [COORD_WIDTH-1:0] o_second_force_x,
    output logic signed [COORD_WIDTH-1:0] o_second_force_y,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int MW   = W + 1;                        // |dx| width
    localparam int RW   = W + 1;                        // root width
    localparam int NW   = 2 * RW;                       // radicand width
    localparam int AEW  = (W + 1 > REST_WIDTH) ? W + 1 : REST_WIDTH;  // |e| width
    localparam int EW   = AEW + 1;                      // signed e width
    localparam int PW   = AEW + MW;                     // |e|*|d| width
    localparam int SPW  = AEW + GAIN_WIDTH - GAIN_FRAC; // scaled spring width
    localparam int VPW  = W + GAIN_WIDTH - GAIN_FRAC;   // scaled damping width
    localparam int SW   = ((SPW > VPW) ? SPW : VPW) + 2;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [REST_WIDTH-1:0] r_rest_length;
    logic [GAIN_WIDTH-1:0] r_spring_gain;
    logic [GAIN_WIDTH-1:0] r_damping_gain;
    logic [DZ_WIDTH-1:0]   r_deadzone;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_length  <= RST_REST_LENGTH;
            r_spring_gain  <= RST_SPRING_GAIN;
            r_damping_gain <= RST_DAMPING_GAIN;
            r_deadzone     <= RST_DEADZONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REST_LENGTH:  r_rest_length  <= i_cfg_data[REST_WIDTH-1:0];
                REG_SPRING_GAIN:  r_spring_gain  <= i_cfg_data[GAIN_WIDTH-1:0];
                REG_DAMPING_GAIN: r_damping_gain <= i_cfg_data[GAIN_WIDTH-1:0];
                REG_DEADZONE:     r_deadzone     <= i_cfg_data[DZ_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: position differences
    // ------------------------------------------------------------------------
    logic                r_s0_valid;
    logic signed [W:0]   r_s0_dx, r_s0_dy;
    logic [4*W-1:0]      r_s0_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start & ~o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_dx  <= {i_first_pos_x[W-1], i_first_pos_x} - {i_second_pos_x[W-1], i_second_pos_x};
        r_s0_dy  <= {i_first_pos_y[W-1], i_first_pos_y} - {i_second_pos_y[W-1], i_second_pos_y};
        r_s0_vel <= {i_second_vel_y, i_second_vel_x, i_first_vel_y, i_first_vel_x};
    end

    // ------------------------------------------------------------------------
    // Stage 1: magnitudes and signs
    // ------------------------------------------------------------------------
    logic            r_s1_valid;
    logic [MW-1:0]   r_s1_ax, r_s1_ay;
    logic            r_s1_sx, r_s1_sy;
    logic [4*W-1:0]  r_s1_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ax  <= r_s0_dx[W] ? (~r_s0_dx + 1'b1) : r_s0_dx;
        r_s1_ay  <= r_s0_dy[W] ? (~r_s0_dy + 1'b1) : r_s0_dy;
        r_s1_sx  <= r_s0_dx[W];
        r_s1_sy  <= r_s0_dy[W];
        r_s1_vel <= r_s0_vel;
    end

    // ------------------------------------------------------------------------
    // Stage 2: squares
    // ------------------------------------------------------------------------
    logic            r_s2_valid;
    logic [NW-1:0]   r_s2_sqx, r_s2_sqy;
    logic [MW-1:0]   r_s2_ax, r_s2_ay;
    logic            r_s2_sx, r_s2_sy;
    logic [4*W-1:0]  r_s2_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sqx <= r_s1_ax * r_s1_ax;
        r_s2_sqy <= r_s1_ay * r_s1_ay;
        r_s2_ax  <= r_s1_ax;
        r_s2_ay  <= r_s1_ay;
        r_s2_sx  <= r_s1_sx;
        r_s2_sy  <= r_s1_sy;
        r_s2_vel <= r_s1_vel;
    end

    // ------------------------------------------------------------------------
    // Square root pipeline: entry 0 holds the radicand, each later entry
    // resolves one root bit (shift-subtract, two radicand bits per stage)
    // ------------------------------------------------------------------------
    logic            r_sq_valid [0:RW];
    logic [NW-1:0]   r_sq_n     [0:RW];
    logic [RW+1:0]   r_sq_rem   [0:RW];
    logic [RW-1:0]   r_sq_root  [0:RW];
    logic [MW-1:0]   r_sq_ax    [0:RW];
    logic [MW-1:0]   r_sq_ay    [0:RW];
    logic            r_sq_sx    [0:RW];
    logic            r_sq_sy    [0:RW];
    logic [4*W-1:0]  r_sq_vel   [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else begin
            r_sq_valid[0] <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_n[0]    <= r_s2_sqx + r_s2_sqy;
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_ax[0]   <= r_s2_ax;
        r_sq_ay[0]   <= r_s2_ay;
        r_sq_sx[0]   <= r_s2_sx;
        r_sq_sy[0]   <= r_s2_sy;
        r_sq_vel[0]  <= r_s2_vel;
    end

    for (genvar k = 1; k <= RW; k++) begin : g_sqrt
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic          take;

        always_comb begin
            rem_sh = {r_sq_rem[k-1][RW-1:0], r_sq_n[k-1][NW-1:NW-2]};
            trial  = {r_sq_root[k-1], 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else begin
                r_sq_valid[k] <= r_sq_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_n[k]    <= {r_sq_n[k-1][NW-3:0], 2'b00};
            r_sq_rem[k]  <= take ? (rem_sh - trial) : rem_sh;
            r_sq_root[k] <= {r_sq_root[k-1][RW-2:0], take};
            r_sq_ax[k]   <= r_sq_ax[k-1];
            r_sq_ay[k]   <= r_sq_ay[k-1];
            r_sq_sx[k]   <= r_sq_sx[k-1];
            r_sq_sy[k]   <= r_sq_sy[k-1];
            r_sq_vel[k]  <= r_sq_vel[k-1];
        end
    end

    // ------------------------------------------------------------------------
    // Stretch stage: e = L - rest_length, magnitude and sign
    // ------------------------------------------------------------------------
    logic signed [EW-1:0] stretch;

    assign stretch = $signed({{(EW-RW){1'b0}}, r_sq_root[RW]})
                   - $signed({{(EW-REST_WIDTH){1'b0}}, r_rest_length});

    logic            r_e_valid;
    logic [AEW-1:0]  r_e_ae;
    logic            r_e_neg;
    logic [RW-1:0]   r_e_len;
    logic [MW-1:0]   r_e_ax, r_e_ay;
    logic            r_e_sx, r_e_sy;
    logic [4*W-1:0]  r_e_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_sq_valid[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ae  <= stretch[EW-1] ? AEW'(-stretch) : stretch[AEW-1:0];
        r_e_neg <= stretch[EW-1];
        r_e_len <= r_sq_root[RW];
        r_e_ax  <= r_sq_ax[RW];
        r_e_ay  <= r_sq_ay[RW];
        r_e_sx  <= r_sq_sx[RW];
        r_e_sy  <= r_sq_sy[RW];
        r_e_vel <= r_sq_vel[RW];
    end

    // ------------------------------------------------------------------------
    // Divide pipelines: entry 0 holds |e|*|d|, each later entry produces one
    // quotient bit of (|e|*|d|) / L; the low word collects the quotient
    // ------------------------------------------------------------------------
    logic [PW-1:0]   prod_x, prod_y;

    assign prod_x = r_e_ae * r_e_ax;
    assign prod_y = r_e_ae * r_e_ay;

    logic            r_dv_valid [0:AEW];
    logic [MW:0]     r_dv_remx  [0:AEW];
    logic [MW:0]     r_dv_remy  [0:AEW];
    logic [AEW-1:0]  r_dv_lox   [0:AEW];
    logic [AEW-1:0]  r_dv_loy   [0:AEW];
    logic [RW-1:0]   r_dv_len   [0:AEW];
    logic [AEW-1:0]  r_dv_ae    [0:AEW];
    logic            r_dv_neg   [0:AEW];
    logic            r_dv_sx    [0:AEW];
    logic            r_dv_sy    [0:AEW];
    logic [4*W-1:0]  r_dv_vel   [0:AEW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else begin
            r_dv_valid[0] <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_remx[0] <= {1'b0, prod_x[PW-1:AEW]};
        r_dv_remy[0] <= {1'b0, prod_y[PW-1:AEW]};
        r_dv_lox[0]  <= prod_x[AEW-1:0];
        r_dv_loy[0]  <= prod_y[AEW-1:0];
        r_dv_len[0]  <= r_e_len;
        r_dv_ae[0]   <= r_e_ae;
        r_dv_neg[0]  <= r_e_neg;
        r_dv_sx[0]   <= r_e_sx;
        r_dv_sy[0]   <= r_e_sy;
        r_dv_vel[0]  <= r_e_vel;
    end

    for (genvar k = 1; k <= AEW; k++) begin : g_div
        logic [MW:0] shx, shy, den;
        logic        gex, gey;

        always_comb begin
            den = {1'b0, r_dv_len[k-1]};
            shx = {r_dv_remx[k-1][MW-1:0], r_dv_lox[k-1][AEW-1]};
            shy = {r_dv_remy[k-1][MW-1:0], r_dv_loy[k-1][AEW-1]};
            gex = (shx >= den);
            gey = (shy >= den);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_remx[k] <= gex ? (shx - den) : shx;
            r_dv_remy[k] <= gey ? (shy - den) : shy;
            r_dv_lox[k]  <= {r_dv_lox[k-1][AEW-2:0], gex};
            r_dv_loy[k]  <= {r_dv_loy[k-1][AEW-2:0], gey};
            r_dv_len[k]  <= r_dv_len[k-1];
            r_dv_ae[k]   <= r_dv_ae[k-1];
            r_dv_neg[k]  <= r_dv_neg[k-1];
            r_dv_sx[k]   <= r_dv_sx[k-1];
            r_dv_sy[k]   <= r_dv_sy[k-1];
            r_dv_vel[k]  <= r_dv_vel[k-1];
        end
    end

    // ------------------------------------------------------------------------
    // Finish stage 1: per-lane spring magnitude/sign, deadzone, velocity
    // magnitude. Lanes: first x, first y, second x, second y.
    // ------------------------------------------------------------------------
    logic            len_zero;
    logic [AEW-1:0]  mag_x, mag_y;
    logic            neg_x, neg_y;
    logic [AEW-1:0]  lane_sm [0:3];
    logic            lane_sn [0:3];

    always_comb begin
        len_zero   = (r_dv_len[AEW] == '0);
        mag_x      = len_zero ? '0 : r_dv_lox[AEW];
        mag_y      = len_zero ? r_dv_ae[AEW] : r_dv_loy[AEW];
        neg_x      = (r_dv_neg[AEW] == r_dv_sx[AEW]);
        // Coincident masses: first y gets -e
        neg_y      = len_zero ? ~r_dv_neg[AEW] : (r_dv_neg[AEW] == r_dv_sy[AEW]);
        lane_sm[0] = mag_x;
        lane_sn[0] = neg_x;
        lane_sm[1] = mag_y;
        lane_sn[1] = neg_y;
        lane_sm[2] = mag_x;
        lane_sn[2] = ~neg_x;
        lane_sm[3] = mag_y;
        lane_sn[3] = ~neg_y;
    end

    logic            r_f1_valid;
    logic [AEW-1:0]  r_f1_sm [0:3];
    logic            r_f1_sn [0:3];
    logic [W-1:0]    r_f1_vm [0:3];
    logic            r_f1_vn [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= r_dv_valid[AEW];
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_f1
        logic [W-1:0] vel;

        assign vel = r_dv_vel[AEW][l*W +: W];

        always_ff @(posedge i_clk) begin
            r_f1_sm[l] <= (lane_sm[l] <= {{(AEW-DZ_WIDTH){1'b0}}, r_deadzone})
                        ? '0 : lane_sm[l];
            r_f1_sn[l] <= lane_sn[l];
            r_f1_vm[l] <= vel[W-1] ? (~vel + 1'b1) : vel;
            r_f1_vn[l] <= vel[W-1];
        end
    end

    // ------------------------------------------------------------------------
    // Finish stage 2: gain products, truncated toward zero
    // ------------------------------------------------------------------------
    logic            r_f2_valid;
    logic [SPW-1:0]  r_f2_sp [0:3];
    logic [VPW-1:0]  r_f2_vp [0:3];
    logic            r_f2_sn [0:3];
    logic            r_f2_vn [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else begin
            r_f2_valid <= r_f1_valid;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_f2
        logic [AEW+GAIN_WIDTH-1:0] sprod;
        logic [W+GAIN_WIDTH-1:0]   vprod;

        assign sprod = r_f1_sm[l] * r_spring_gain;
        assign vprod = r_f1_vm[l] * r_damping_gain;

        always_ff @(posedge i_clk) begin
            r_f2_sp[l] <= sprod[AEW+GAIN_WIDTH-1:GAIN_FRAC];
            r_f2_vp[l] <= vprod[W+GAIN_WIDTH-1:GAIN_FRAC];
            r_f2_sn[l] <= r_f1_sn[l];
            r_f2_vn[l] <= r_f1_vn[l];
        end
    end

    // ------------------------------------------------------------------------
    // Finish stage 3: signed combine and saturation into the output registers
    // ------------------------------------------------------------------------
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic [W-1:0] lane_out [0:3];

    for (genvar l = 0; l < 4; l++) begin : g_f3
        logic signed [SW-1:0] sp, vp, total;

        always_comb begin
            sp    = $signed({{(SW-SPW){1'b0}}, r_f2_sp[l]});
            vp    = $signed({{(SW-VPW){1'b0}}, r_f2_vp[l]});
            total = (r_f2_sn[l] ? -sp : sp) - (r_f2_vn[l] ? -vp : vp);
            if (total > SAT_MAX) begin
                lane_out[l] = SAT_MAX[W-1:0];
            end else if (total < SAT_MIN) begin
                lane_out[l] = SAT_MIN[W-1:0];
            end else begin
                lane_out[l] = total[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_first_force_x  <= lane_out[0];
        o_first_force_y  <= lane_out[1];
        o_second_force_x <= lane_out[2];
        o_second_force_y <= lane_out[3];
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for damped_spring_force. Spring items stream from a
// queue with random start gaps; every accepted transaction is predicted in
// wide integer arithmetic and every result strobe is checked in order.
// Register settings change between phases while the pipeline is drained.
// ============================================================================
module tb;
    import dsf_pkg::*;

    localparam int CW        = DSF_COORD_WIDTH;
    localparam int LATENCY   = 2 * CW + 10;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [CW-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    } spring_t;

    typedef struct packed {
        logic signed [CW-1:0] f1x, f1y, f2x, f2y;
    } force_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic signed [CW-1:0] i_first_pos_x = '0, i_first_pos_y = '0;
    logic signed [CW-1:0] i_second_pos_x = '0, i_second_pos_y = '0;
    logic signed [CW-1:0] i_first_vel_x = '0, i_first_vel_y = '0;
    logic signed [CW-1:0] i_second_vel_x = '0, i_second_vel_y = '0;
    logic o_valid;
    logic signed [CW-1:0] o_first_force_x, o_first_force_y;
    logic signed [CW-1:0] o_second_force_x, o_second_force_y;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data = '0;

    damped_spring_force dut (.*);

    always #5 i_clk = ~i_clk;

    // Register shadow copy
    logic [REST_WIDTH-1:0] rest_len = RST_REST_LENGTH;
    logic [GAIN_WIDTH-1:0] k_spring = RST_SPRING_GAIN;
    logic [GAIN_WIDTH-1:0] k_damp   = RST_DAMPING_GAIN;
    logic [DZ_WIDTH-1:0]   dead_z   = RST_DEADZONE;

    spring_t pending_springs[$];
    force_t  expected_forces[$];
    spring_t drv_spring;
    int      gap_left = 0;
    bit      burst    = 0;
    int      err_cnt  = 0;
    int      cycle_cnt = 0;

    // Truncated signed product with a Q8.16 gain
    function automatic logic signed [127:0] apply_gain(logic signed [127:0] v,
                                                       logic [GAIN_WIDTH-1:0] g);
        logic signed [127:0] m;
        m = v < 0 ? -v : v;
        m = (m * $signed({104'd0, g})) >>> GAIN_FRAC;
        return v < 0 ? -m : m;
    endfunction

    // Deadzone, gains and saturation of one force component
    function automatic logic signed [CW-1:0] force_out(logic signed [127:0] spring,
                                                       logic signed [CW-1:0] vel);
        logic signed [127:0] s, hi, lo, av;
        hi = (128'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        av = spring < 0 ? -spring : spring;
        if (av <= $signed({112'd0, dead_z}))
            spring = 0;
        s = apply_gain(spring, k_spring) - apply_gain(128'(vel), k_damp);
        if (s > hi) s = hi;
        if (s < lo) s = lo;
        return s[CW-1:0];
    endfunction

    function automatic force_t calc_force(spring_t sp);
        logic signed [127:0] dx, dy, ax, ay, n, c, len, e, ae, fx, fy;
        force_t f;
        dx = 128'(sp.p1x) - 128'(sp.p2x);
        dy = 128'(sp.p1y) - 128'(sp.p2y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        n = ax * ax + ay * ay;
        len = 0;
        for (int b = 62; b >= 0; b--) begin
            c = len | (128'sd1 <<< b);
            if (c * c <= n) len = c;
        end
        e  = len - $signed({97'd0, rest_len});
        ae = e < 0 ? -e : e;
        if (len == 0) begin
            // coincident masses: direction taken as +y
            fx = 0;
            fy = -e;
        end else begin
            fx = (ae * ax) / len;
            fy = (ae * ay) / len;
            if ((e < 0) == (dx < 0)) fx = -fx;
            if ((e < 0) == (dy < 0)) fy = -fy;
        end
        f.f1x = force_out(fx, sp.v1x);
        f.f1y = force_out(fy, sp.v1y);
        f.f2x = force_out(-fx, sp.v2x);
        f.f2y = force_out(-fy, sp.v2y);
        return f;
    endfunction

    // Driver: one spring per transaction, random gaps, bursts without gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy)
                expected_forces.push_back(calc_force(drv_spring));
            if (!(i_start && o_busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_start  <= 1'b0;
                end else if (pending_springs.size() > 0) begin
                    drv_spring      = pending_springs.pop_front();
                    i_first_pos_x  <= drv_spring.p1x;
                    i_first_pos_y  <= drv_spring.p1y;
                    i_second_pos_x <= drv_spring.p2x;
                    i_second_pos_y <= drv_spring.p2y;
                    i_first_vel_x  <= drv_spring.v1x;
                    i_first_vel_y  <= drv_spring.v1y;
                    i_second_vel_x <= drv_spring.v2x;
                    i_second_vel_y <= drv_spring.v2y;
                    i_start        <= 1'b1;
                    if ($urandom_range(0, 31) == 0) burst = ~burst;
                    gap_left <= burst ? 0 : $urandom_range(0, 15);
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobe with the oldest expectation
    always @(posedge i_clk) begin
        force_t exp_f;
        if (i_rst_n && o_valid) begin
            if (expected_forces.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                err_cnt++;
            end else begin
                exp_f = expected_forces.pop_front();
                if (o_first_force_x !== exp_f.f1x) begin
                    $error("first_force_x exp %0d got %0d", exp_f.f1x, o_first_force_x);
                    err_cnt++;
                end
                if (o_first_force_y !== exp_f.f1y) begin
                    $error("first_force_y exp %0d got %0d", exp_f.f1y, o_first_force_y);
                    err_cnt++;
                end
                if (o_second_force_x !== exp_f.f2x) begin
                    $error("second_force_x exp %0d got %0d", exp_f.f2x, o_second_force_x);
                    err_cnt++;
                end
                if (o_second_force_y !== exp_f.f2y) begin
                    $error("second_force_y exp %0d got %0d", exp_f.f2y, o_second_force_y);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("status: fail");
            $finish;
        end
    end

    // Register write; caller drops i_cfg_valid after the last one
    task automatic reg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_REST_LENGTH:  rest_len = val[REST_WIDTH-1:0];
            REG_SPRING_GAIN:  k_spring = val[GAIN_WIDTH-1:0];
            REG_DAMPING_GAIN: k_damp   = val[GAIN_WIDTH-1:0];
            REG_DEADZONE:     dead_z   = val[DZ_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] r, logic [31:0] ks, logic [31:0] kd, logic [31:0] dz);
        reg_write(REG_REST_LENGTH, r);
        reg_write(REG_SPRING_GAIN, ks);
        reg_write(REG_DAMPING_GAIN, kd);
        reg_write(REG_DEADZONE, dz);
        i_cfg_valid <= 1'b0;
    endtask

    // Full range a quarter of the time for the bits; small values keep forces unsaturated
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
            2:       return $signed($urandom_range(0, 2 ** 25)) - 2 ** 24;
            default: return $signed($urandom_range(0, 2 ** 17)) - 2 ** 16;
        endcase
    endfunction

    function automatic spring_t rand_spring();
        spring_t s;
        s.p1x = rand_coord(); s.p1y = rand_coord();
        s.p2x = rand_coord(); s.p2y = rand_coord();
        s.v1x = rand_coord(); s.v1y = rand_coord();
        s.v2x = rand_coord(); s.v2y = rand_coord();
        // occasional coincident or axis-aligned masses
        case ($urandom_range(0, 15))
            0: begin s.p2x = s.p1x; s.p2y = s.p1y; end
            1: s.p2x = s.p1x;
            2: s.p2y = s.p1y;
            default: ;
        endcase
        return s;
    endfunction

    task automatic run_random(int count);
        repeat (count) pending_springs.push_back(rand_spring());
    endtask

    task automatic drain();
        while (pending_springs.size() > 0 || i_start || expected_forces.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

    initial begin
        spring_t s;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases under reset defaults
        s = '0;                                          pending_springs.push_back(s);
        s = '{SMAX, SMAX, SMIN, SMIN, SMAX, SMIN, SMIN, SMAX}; pending_springs.push_back(s);
        s = '{SMIN, SMIN, SMAX, SMAX, SMIN, SMAX, SMAX, SMIN}; pending_springs.push_back(s);
        s = '{SMAX, 0, SMIN, 0, 0, 0, 0, 0};             pending_springs.push_back(s);
        s = '{0, SMIN, 0, SMAX, -1, -1, -1, -1};         pending_springs.push_back(s);
        s = '{32'sh30000, 32'sh40000, 0, 0, 0, 0, 0, 0}; pending_springs.push_back(s);
        s = '{32'sd100, 0, 0, 0, 0, 0, 0, 0};            pending_springs.push_back(s);
        s = '{32'sd655, 0, 0, 0, 0, 0, 0, 0};            pending_springs.push_back(s);
        s = '{32'sd656, 0, 0, 0, 0, 0, 0, 0};            pending_springs.push_back(s);
        s = '{-32'sd656, 32'sd1, 0, 0, 1, 1, 1, 1};      pending_springs.push_back(s);
        drain();

        // Stretch and compression, coincident with nonzero rest, damping on
        set_regs(32'h0002_0000, 32'h0001_8000, 32'h0000_4000, 32'd0);
        s = '0;                                          pending_springs.push_back(s);
        s = '{32'sh10000, 0, 0, 0, 32'sh7000, 0, 0, 0};  pending_springs.push_back(s);
        s = '{0, 32'sh50000, 0, 0, 0, SMIN, SMAX, 0};    pending_springs.push_back(s);
        s = '{SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, SMIN}; pending_springs.push_back(s);
        run_random(250);
        drain();

        // Register extremes; data bits above each width are dropped
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        reg_write(8'hFF, 32'h1234_5678);
        i_cfg_valid <= 1'b0;
        s = '0;                                          pending_springs.push_back(s);
        s = '{SMAX, SMAX, SMIN, SMIN, SMAX, SMIN, SMIN, SMAX}; pending_springs.push_back(s);
        run_random(250);
        drain();

        set_regs(32'd0, 32'd0, 32'd0, 32'd0);
        s = '{32'sd1, 0, 0, 0, SMIN, SMAX, 0, 0};        pending_springs.push_back(s);
        run_random(250);
        drain();

        set_regs(32'd0, 32'h00FF_FFFF, 32'd0, 32'd0);
        run_random(250);
        drain();

        repeat (3) begin
            set_regs($urandom, $urandom_range(0, 32'h0004_0000),
                     $urandom_range(0, 32'h0004_0000), $urandom_range(0, 4000));
            run_random(180);
            drain();
        end

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
